@@ design/json_string_escaper_core_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the json string escaper
// concurrent checks written in one form across the project
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_CORE_ASSERT_SVH
`define JSON_STRING_ESCAPER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define JSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("jse assertion failed");

// next-cycle implication, disabled while reset is asserted
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("jse assertion failed");

`endif

@@ design/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, character codes and helpers of the json string escaper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

  localparam int unsigned JseFifoDepth = 4;

  // raw input bytes with special meaning
  localparam logic [7:0] ByteQuote     = 8'h22;
  localparam logic [7:0] ByteBackslash = 8'h5C;
  localparam logic [7:0] ByteBackspace = 8'h08;
  localparam logic [7:0] ByteFormFeed  = 8'h0C;
  localparam logic [7:0] ByteNewline   = 8'h0A;
  localparam logic [7:0] ByteReturn    = 8'h0D;
  localparam logic [7:0] ByteTab       = 8'h09;
  localparam logic [7:0] BytePrintLo   = 8'h20;
  localparam logic [7:0] BytePrintHi   = 8'h7E;
  localparam logic [2:0] LeadPrefix    = 3'b110;

  // output characters
  localparam logic [6:0] CharQuote     = 7'h22;
  localparam logic [6:0] CharBackslash = 7'h5C;
  localparam logic [6:0] CharB         = 7'h62;
  localparam logic [6:0] CharF         = 7'h66;
  localparam logic [6:0] CharN         = 7'h6E;
  localparam logic [6:0] CharR         = 7'h72;
  localparam logic [6:0] CharT         = 7'h74;
  localparam logic [6:0] CharU         = 7'h75;
  localparam logic [6:0] CharZero      = 7'h30;
  localparam logic [6:0] CharQuestion  = 7'h3F;
  localparam logic [6:0] HexLetterBase = 7'h37;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_PAIR = 2'd1,
    KIND_UNI  = 2'd2
  } jse_kind_e;

  // one queued output run
  typedef struct packed {
    jse_kind_e   kind;
    logic [6:0]  ch;
    logic [10:0] code;
  } jse_cmd_t;

  typedef struct packed {
    logic push;
    logic lead_pending;
  } jse_front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jse_fifo_stat_t;

  function automatic logic [6:0] jse_hex(input logic [3:0] nib);
    logic [6:0] ext;
    ext = {3'b000, nib};
    return (nib < 4'd10) ? (CharZero + ext) : (HexLetterBase + ext);
  endfunction

  function automatic logic [2:0] jse_len(input jse_kind_e kind);
    logic [2:0] len;
    unique case (kind)
      KIND_CHAR: len = 3'd1;
      KIND_PAIR: len = 3'd2;
      KIND_UNI:  len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [6:0] jse_char_at(input jse_cmd_t cmd, input logic [2:0] idx);
    logic [6:0] c;
    unique case (cmd.kind)
      KIND_CHAR: c = cmd.ch;
      KIND_PAIR: c = (idx == 3'd0) ? CharBackslash : cmd.ch;
      KIND_UNI: begin
        unique case (idx)
          3'd0:    c = CharBackslash;
          3'd1:    c = CharU;
          3'd2:    c = CharZero;
          3'd3:    c = jse_hex({1'b0, cmd.code[10:8]});
          3'd4:    c = jse_hex(cmd.code[7:4]);
          default: c = jse_hex(cmd.code[3:0]);
        endcase
      end
      default:   c = CharQuestion;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/jse_if.sv @@
// ----------------------------------------------------------------------------
// jse channel interfaces
// valid/ready channels for raw bytes in and escaped characters out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ design/jse_front.sv @@
// ----------------------------------------------------------------------------
// jse_front
// classifies raw bytes into output runs and tracks a pending utf-8 lead
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  end_of_text_i,
  output jse_pkg::jse_cmd_t          cmd_o,
  output jse_pkg::jse_front_stat_t   stat_o
);
  import jse_pkg::*;

  logic       pending_q, pending_d;
  logic [4:0] bits_q, bits_d;
  logic       has_cmd;
  jse_cmd_t   cmd;

  always_comb begin
    has_cmd   = 1'b1;
    cmd.kind  = KIND_CHAR;
    cmd.ch    = CharQuestion;
    cmd.code  = {bits_q, in_byte_i[5:0]};
    pending_d = pending_q;
    bits_d    = bits_q;
    if (accept_i) begin
      pending_d = 1'b0;
      bits_d    = '0;
    end
    priority if (pending_q) begin
      cmd.kind = KIND_UNI;
    end else if (in_byte_i == ByteQuote) begin
      cmd.kind = KIND_PAIR;
      cmd.ch   = CharQuote;
    end else if (in_byte_i == ByteBackslash) begin
      cmd.kind = KIND_PAIR;
      cmd.ch   = CharBackslash;
    end else if (in_byte_i == ByteBackspace) begin
      cmd.kind = KIND_PAIR;
      cmd.ch   = CharB;
    end else if (in_byte_i == ByteFormFeed) begin
      cmd.kind = KIND_PAIR;
      cmd.ch   = CharF;
    end else if (in_byte_i == ByteNewline) begin
      cmd.kind = KIND_PAIR;
      cmd.ch   = CharN;
    end else if (in_byte_i == ByteReturn) begin
      cmd.kind = KIND_PAIR;
      cmd.ch   = CharR;
    end else if (in_byte_i == ByteTab) begin
      cmd.kind = KIND_PAIR;
      cmd.ch   = CharT;
    end else if (in_byte_i >= BytePrintLo && in_byte_i <= BytePrintHi) begin
      cmd.ch = in_byte_i[6:0];
    end else if (in_byte_i[7:5] == LeadPrefix && !end_of_text_i) begin
      // lead byte waits for its continuation, nothing emitted yet
      has_cmd = 1'b0;
      if (accept_i) begin
        pending_d = 1'b1;
        bits_d    = in_byte_i[4:0];
      end
    end else begin
      cmd.ch = CharQuestion;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      bits_q    <= '0;
    end else begin
      pending_q <= pending_d;
      bits_q    <= bits_d;
    end
  end

  assign cmd_o               = cmd;
  assign stat_o.push         = accept_i && has_cmd;
  assign stat_o.lead_pending = pending_q;

endmodule

`default_nettype wire

@@ design/jse_fifo.sv @@
// ----------------------------------------------------------------------------
// jse_fifo
// short run queue between the classifier and the character sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_fifo #(
  parameter int unsigned Depth = jse_pkg::JseFifoDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  jse_pkg::jse_cmd_t        push_data_i,
  input  wire logic                pop_i,
  output jse_pkg::jse_cmd_t        head_o,
  output jse_pkg::jse_fifo_stat_t  stat_o
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jse_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i && (cnt_q != FullCnt);
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

@@ design/jse_back.sv @@
// ----------------------------------------------------------------------------
// jse_back
// expands queued runs into characters, one per cycle while the output is ready, into an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  jse_pkg::jse_cmd_t        head_i,
  input  jse_pkg::jse_fifo_stat_t  fifo_stat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [6:0]               out_char_o,
  output logic                     out_last_o
);
  import jse_pkg::*;

  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  jse_cmd_t   cur_q, cur_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;

  jse_cmd_t   src;
  logic [2:0] src_idx;
  logic       have;
  logic       load;
  logic       src_last;

  always_comb begin
    src      = busy_q ? cur_q : head_i;
    src_idx  = busy_q ? idx_q : 3'd0;
    have     = busy_q || !fifo_stat_i.empty;
    load     = !valid_q || out_ready_i;
    src_last = (src_idx == jse_len(src.kind) - 3'd1);
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = have;
      if (have) begin
        char_d = jse_char_at(src, src_idx);
        last_d = src_last;
        pop_o  = !busy_q;
        if (src_last) begin
          busy_d = 1'b0;
        end else begin
          busy_d = 1'b1;
          cur_d  = src;
          idx_d  = src_idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

@@ design/json_string_escaper_core.sv @@
// an accepted byte's run is written into the run queue, and its characters are later loaded into the output register;
//   a lead byte's run comes out with its continuation
// throughput: one byte accepted per cycle while the run queue has room; the output
//   register drains one character per cycle while the output is ready, so an escape becomes 2 or 6 characters
// the run queue depth (FifoDepth) sets how long escapes can be absorbed without stalling input
// reset: asynchronous active low, clears the pending lead, the queue and the output register
// ----------------------------------------------------------------------------
// json_string_escaper_core
// streaming json string escaper: raw bytes in, escaped printable characters out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "json_string_escaper_core_assert.svh"

module json_string_escaper_core #(
  parameter int unsigned FifoDepth = jse_pkg::JseFifoDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  jse_in_if.sink      in_i,
  jse_out_if.source   out_o
);
  import jse_pkg::*;

  // front to queue
  jse_cmd_t        front_cmd;
  jse_front_stat_t front_stat;
  logic            in_accept;

  // queue to back
  jse_cmd_t        head;
  jse_fifo_stat_t  fifo_stat;
  logic            pop;

  // input is taken whenever the queue can hold another run, even when the
  // byte turns out to produce nothing (a held lead byte)
  assign in_i.ready = !fifo_stat.full;
  assign in_accept  = in_i.valid && !fifo_stat.full;

  // classifier: decides the run for each byte, owns the lead state
  jse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .in_byte_i     (in_i.in_byte),
    .end_of_text_i (in_i.end_of_text),
    .cmd_o         (front_cmd),
    .stat_o        (front_stat)
  );

  // run queue decouples byte intake from character output
  jse_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_stat.push),
    .push_data_i (front_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  // sequencer: walks each run and feeds the output register
  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .out_last_o  (out_o.last_of_run)
  );

  // a run is never pushed into a full queue
  `JSE_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, front_stat.push, !fifo_stat.full)
  // the sequencer only pops an occupied queue
  `JSE_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop, !fifo_stat.empty)
  // the byte after a held lead always becomes a unicode escape run
  `JSE_ASSERT_IMPL(a_lead_completes, clk_i, rst_ni, front_stat.lead_pending && in_accept,
                   front_stat.push && front_cmd.kind == KIND_UNI)
  // accepting the byte after a held lead clears the pending mark on the next cycle
  `JSE_ASSERT_NEXT(a_lead_cleared, clk_i, rst_ni, front_stat.lead_pending && in_accept,
                   !front_stat.lead_pending)

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the json string escaper: raw bytes go in over a
// valid/ready channel and every escaped character that comes out is compared
// with a software prediction of the escaping rules, with random stalls on
// both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import jse_pkg::*;

  localparam int unsigned RandomItems   = 305;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned LongHoldAfter = 80;   // characters seen before the long hold
  localparam int unsigned LongHoldLen   = 80;   // cycles the receiver holds off
  localparam int unsigned DrainAt       = 150;  // random items before the mid-run drain
  localparam logic [6:0]  CharA         = 7'h41;

  // one expected output character
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_exp_t;

  // one directed row: an optional hand-written expected run
  typedef struct {
    logic [7:0] raw;
    logic       eot;
    bit         typed;
    string      text;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  jse_in_if  byte_if ();
  jse_out_if char_if ();

  json_string_escaper_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (char_if)
  );

  // predictor state, mirrors the pending two-byte sequence
  logic       lead_waiting;
  logic [4:0] lead_low_bits;
  logic [6:0] run_chars[$];     // characters caused by the latest byte
  char_exp_t  pending_chars[$]; // characters still owed by the dut

  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned unicode_runs;
  int unsigned chars_checked;
  int unsigned cycle_count;
  int          send_quiet;
  int          recv_quiet;
  bit          long_hold_done;

  // directed rows: extremes of the printable range, every escape, bytes that
  // fall outside every class, a lead at end of text, and continuations that
  // are full-range, zero, another lead or plain ascii
  dir_row_t dir_rows[25] = '{
    '{8'h20, 1'b0, 1'b1, " "},
    '{8'h7E, 1'b1, 1'b1, "~"},
    '{8'h22, 1'b0, 1'b1, "\\\""},
    '{8'h5C, 1'b0, 1'b1, "\\\\"},
    '{8'h08, 1'b1, 1'b1, "\\b"},
    '{8'h0C, 1'b0, 1'b1, "\\f"},
    '{8'h0A, 1'b0, 1'b1, "\\n"},
    '{8'h0D, 1'b0, 1'b1, "\\r"},
    '{8'h09, 1'b1, 1'b1, "\\t"},
    '{8'h00, 1'b0, 1'b1, "?"},
    '{8'h1F, 1'b0, 1'b1, "?"},
    '{8'h7F, 1'b0, 1'b1, "?"},
    '{8'hFF, 1'b1, 1'b1, "?"},
    '{8'hBF, 1'b0, 1'b1, "?"},
    '{8'hE0, 1'b0, 1'b1, "?"},
    '{8'hC0, 1'b1, 1'b1, "?"},
    '{8'hDF, 1'b0, 1'b0, ""},
    '{8'hFF, 1'b0, 1'b0, ""},
    '{8'hC0, 1'b0, 1'b0, ""},
    '{8'h00, 1'b1, 1'b0, ""},
    '{8'hC5, 1'b0, 1'b0, ""},
    '{8'hD3, 1'b0, 1'b0, ""},
    '{8'hC9, 1'b0, 1'b0, ""},
    '{8'h41, 1'b0, 1'b0, ""},
    '{8'h41, 1'b1, 1'b0, ""}
  };

  // clock and reset
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // one upper-case hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CharZero + {3'b000, nib};
    return CharA + {3'b000, nib} - 7'd10;
  endfunction

  // escapes one raw byte into run_chars and advances the lead state
  function automatic void escape_byte(input logic [7:0] raw, input logic eot);
    logic [10:0] cp;
    run_chars.delete();
    if (lead_waiting) begin
      // second byte of a pair is taken whatever its value, low six bits only
      cp = {lead_low_bits, raw[5:0]};
      lead_waiting  = 1'b0;
      lead_low_bits = 5'd0;
      run_chars = '{CharBackslash, CharU, CharZero, hex_char({1'b0, cp[10:8]}),
                    hex_char(cp[7:4]), hex_char(cp[3:0])};
      unicode_runs++;
    end else begin
      case (raw)
        ByteQuote:     run_chars = '{CharBackslash, CharQuote};
        ByteBackslash: run_chars = '{CharBackslash, CharBackslash};
        ByteBackspace: run_chars = '{CharBackslash, CharB};
        ByteFormFeed:  run_chars = '{CharBackslash, CharF};
        ByteNewline:   run_chars = '{CharBackslash, CharN};
        ByteReturn:    run_chars = '{CharBackslash, CharR};
        ByteTab:       run_chars = '{CharBackslash, CharT};
        default: begin
          if (raw >= BytePrintLo && raw <= BytePrintHi) begin
            run_chars = '{raw[6:0]};
          end else if (raw[7:5] == LeadPrefix && !eot) begin
            // lead byte: nothing out yet, keep the five payload bits
            lead_waiting  = 1'b1;
            lead_low_bits = raw[4:0];
          end else begin
            // lead at end of text, or any other byte
            run_chars = '{CharQuestion};
          end
        end
      endcase
    end
  endfunction

  // idle length: mostly none or short, a few long, with idle-free stretches
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      quiet = $urandom_range(40, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // offers one byte, waits for the transaction, then queues what it should
  // produce (the hand-written run where one is given)
  task automatic send_raw(input logic [7:0] raw, input logic eot,
                          input bit typed = 1'b0, input string text = "");
    int gap;
    int i;
    logic [7:0] text_byte;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      @(negedge clk_i);
      byte_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    byte_if.valid       <= 1'b1;
    byte_if.in_byte     <= raw;
    byte_if.end_of_text <= eot;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
    bytes_sent++;
    // the predictor always runs so the lead state stays in step
    escape_byte(raw, eot);
    if (typed) begin
      run_chars.delete();
      for (i = 0; i < text.len(); i++) begin
        text_byte = text[i];
        run_chars.push_back(text_byte[6:0]);
      end
    end
    for (i = 0; i < run_chars.size(); i++) begin
      pending_chars.push_back('{ch: run_chars[i], last: (i == run_chars.size() - 1)});
    end
  endtask

  // receiver: random stalls, plus one long hold while the sender keeps going
  // so the run queue fills up and input backpressure is exercised
  initial begin
    int gap;
    char_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && chars_checked >= LongHoldAfter) begin
        long_hold_done = 1'b1;
        @(negedge clk_i);
        char_if.ready <= 1'b0;
        repeat (LongHoldLen - 1) @(negedge clk_i);
      end
      gap = pick_gap(recv_quiet);
      if (gap > 0) begin
        @(negedge clk_i);
        char_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      char_if.ready <= 1'b1;
    end
  end

  // output check: every transaction against the oldest expected character
  always @(posedge clk_i) begin
    char_exp_t exp_c;
    if (rst_ni === 1'b1 && char_if.valid === 1'b1 && char_if.ready === 1'b1) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected char 0x%02h last %0b, nothing expected",
                 $time, char_if.out_char, char_if.last_of_run);
      end else begin
        exp_c = pending_chars.pop_front();
        if (char_if.out_char !== exp_c.ch || char_if.last_of_run !== exp_c.last) begin
          mismatch_count++;
          $display("%0t: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                   $time, exp_c.ch, exp_c.last, char_if.out_char, char_if.last_of_run);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d characters still expected", $time, pending_chars.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    int n;
    int pick;
    logic [7:0] lead;
    bit drained;

    lead_waiting        = 1'b0;
    lead_low_bits       = 5'd0;
    mismatch_count      = 0;
    bytes_sent          = 0;
    unicode_runs        = 0;
    chars_checked       = 0;
    cycle_count         = 0;
    send_quiet          = 0;
    recv_quiet          = 0;
    long_hold_done      = 1'b0;
    drained             = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.in_byte     = 8'h00;
    byte_if.end_of_text = 1'b0;

    // single reset at the start of the run
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    foreach (dir_rows[k]) begin
      send_raw(dir_rows[k].raw, dir_rows[k].eot, dir_rows[k].typed, dir_rows[k].text);
    end

    // random part: mostly well-formed text, many two-byte sequences
    n = 0;
    while (n < RandomItems) begin
      pick = $urandom_range(99);
      lead = {LeadPrefix, 5'($urandom)};
      if (pick < 30) begin
        // lead then a continuation of any value
        send_raw(lead, 1'b0);
        send_raw(8'($urandom), ($urandom_range(7) == 0));
        n += 2;
      end else if (pick < 38) begin
        // lead that closes the text
        send_raw(lead, 1'b1);
        n++;
      end else if (pick < 55) begin
        case ($urandom_range(6))
          0:       send_raw(ByteQuote, ($urandom_range(7) == 0));
          1:       send_raw(ByteBackslash, ($urandom_range(7) == 0));
          2:       send_raw(ByteBackspace, ($urandom_range(7) == 0));
          3:       send_raw(ByteFormFeed, ($urandom_range(7) == 0));
          4:       send_raw(ByteNewline, ($urandom_range(7) == 0));
          5:       send_raw(ByteReturn, ($urandom_range(7) == 0));
          default: send_raw(ByteTab, ($urandom_range(7) == 0));
        endcase
        n++;
      end else if (pick < 85) begin
        send_raw(8'($urandom_range(BytePrintHi, BytePrintLo)), ($urandom_range(7) == 0));
        n++;
      end else begin
        // noise: any byte at all, including stray leads
        send_raw(8'($urandom_range(255)), ($urandom_range(7) == 0));
        n++;
      end

      // once mid-run: stop offering until every expected character is out
      if (!drained && n >= DrainAt) begin
        drained = 1'b1;
        @(negedge clk_i);
        byte_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk_i);
      end
    end

    @(negedge clk_i);
    byte_if.valid <= 1'b0;

    // drain, then idle for anything stray
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes (%0d unicode escapes), checked %0d output characters",
             bytes_sent, unicode_runs, chars_checked);
    $display("long output hold %0s, mid-run drain %0s",
             long_hold_done ? "done" : "missed", drained ? "done" : "missed");
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/jse_pkg.sv
design/jse_if.sv
design/jse_front.sv
design/jse_fifo.sv
design/jse_back.sv
design/json_string_escaper_core.sv
dv/tb_top.sv
